// File: rtl/rgb_led_strip_bit_encoder_assert.svh
// ---------------------------------------------------------------------------
// rgb led strip bit encoder assertion macros
// concurrent checks on the encoder clock, switched off by NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef RGB_LED_STRIP_BIT_ENCODER_ASSERT_SVH
`define RGB_LED_STRIP_BIT_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define RLSE_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RLSE_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RLSE_CHECK(label, prop, msg)
`define RLSE_CHECK_ALWAYS(label, prop, msg)

`endif

`endif

// File: rtl/rlse_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_pkg
// shared constants, register map and types of the led strip bit encoder
// ---------------------------------------------------------------------------
package rlse_pkg;

  localparam int COLOR_W        = 8;
  localparam int DUTY_W         = 8;
  localparam int LENGTH_W       = 11;
  localparam int LATCH_W        = 6;
  localparam int BITS_PER_PIXEL = 24;
  localparam int MAX_LEDS_DEF   = 1024;
  localparam int MAX_LATCH_DEF  = 48;

  // slot counter covers the longer of a pixel run and a reset run
  localparam int CNT_W = 6;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_ZERO_DUTY    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ONE_DUTY     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRIP_LENGTH = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LATCH_SLOTS  = 2'd3;

  localparam logic [DUTY_W-1:0]   ZERO_DUTY_RST    = 8'd19;
  localparam logic [DUTY_W-1:0]   ONE_DUTY_RST     = 8'd38;
  localparam logic [LENGTH_W-1:0] STRIP_LENGTH_RST = 11'd1;
  localparam logic [LATCH_W-1:0]  LATCH_SLOTS_RST  = 6'd48;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [DUTY_W-1:0]   zero_duty;
    logic [DUTY_W-1:0]   one_duty;
    logic [LENGTH_W-1:0] strip_length;
    logic [LATCH_W-1:0]  latch_slots;
  } cfg_t;

  // one run of slots for the back end
  typedef struct packed {
    logic                      is_latch;
    logic [BITS_PER_PIXEL-1:0] grb;
    logic [CNT_W-1:0]          rem;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic                latched;
    logic [LENGTH_W-1:0] pixels_sent;
  } front_stat_t;

endpackage

// File: rtl/rlse_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_in_if
// pixel channel: frame start or grb colour word
// ---------------------------------------------------------------------------
interface rlse_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;

  modport source(output valid, mode, green, red, blue, input ready);
  modport sink(input valid, mode, green, red, blue, output ready);
endinterface

// File: rtl/rlse_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_out_if
// slot channel: one pulse compare value per bit period
// ---------------------------------------------------------------------------
interface rlse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot_duty;
  logic       reset_slot;
  logic       last_of_run;

  modport source(output valid, slot_duty, reset_slot, last_of_run, input ready);
  modport sink(input valid, slot_duty, reset_slot, last_of_run, output ready);
endinterface

// File: rtl/rlse_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_cfg
// apb register file holding duties, strip length and reset slot count
// ---------------------------------------------------------------------------
module rlse_cfg import rlse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_duty    <= ZERO_DUTY_RST;
      cfg.one_duty     <= ONE_DUTY_RST;
      cfg.strip_length <= STRIP_LENGTH_RST;
      cfg.latch_slots  <= LATCH_SLOTS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ZERO_DUTY:    cfg.zero_duty    <= pwdata[DUTY_W-1:0];
        REG_ONE_DUTY:     cfg.one_duty     <= pwdata[DUTY_W-1:0];
        REG_STRIP_LENGTH: cfg.strip_length <= pwdata[LENGTH_W-1:0];
        REG_LATCH_SLOTS:  cfg.latch_slots  <= pwdata[LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ZERO_DUTY:    prdata = DATA_W'(cfg.zero_duty);
      REG_ONE_DUTY:     prdata = DATA_W'(cfg.one_duty);
      REG_STRIP_LENGTH: prdata = DATA_W'(cfg.strip_length);
      REG_LATCH_SLOTS:  prdata = DATA_W'(cfg.latch_slots);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/rlse_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_front
// takes pixel words, tracks the frame and queues pixel or reset runs
// ---------------------------------------------------------------------------
module rlse_front import rlse_pkg::*; #(
  parameter int MAX_LEDS        = MAX_LEDS_DEF,
  parameter int MAX_LATCH_SLOTS = MAX_LATCH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rlse_in_if.sink     pixel,
  input  cfg_t        cfg,
  input  q_stat_t     q_st,
  output logic        push,
  output cmd_t        cmd,
  output front_stat_t stat
);

  localparam int LEN_W = ($clog2(MAX_LEDS + 1) > LENGTH_W) ? $clog2(MAX_LEDS + 1) : LENGTH_W;

  logic [LENGTH_W-1:0] pixels_sent, pixels_sent_next;
  logic                latched, latched_next;
  logic                take;
  logic                room;
  logic [LEN_W-1:0]    len_eff;
  logic [LATCH_W-1:0]  nlatch;

  assign pixel.ready = !q_st.full;
  assign take        = pixel.valid && pixel.ready;

  assign stat.latched     = latched;
  assign stat.pixels_sent = pixels_sent;

  always_comb begin
    if (LEN_W'(cfg.strip_length) > LEN_W'(MAX_LEDS)) begin
      len_eff = LEN_W'(MAX_LEDS);
    end else begin
      len_eff = LEN_W'(cfg.strip_length);
    end
    if (cfg.latch_slots == '0) begin
      nlatch = LATCH_W'(1);
    end else if (cfg.latch_slots > LATCH_W'(MAX_LATCH_SLOTS)) begin
      nlatch = LATCH_W'(MAX_LATCH_SLOTS);
    end else begin
      nlatch = cfg.latch_slots;
    end
  end

  assign room = LEN_W'(pixels_sent) < len_eff;

  always_comb begin
    pixels_sent_next = pixels_sent;
    latched_next     = latched;
    push             = 1'b0;
    cmd.is_latch     = !room;
    cmd.grb          = {pixel.green, pixel.red, pixel.blue};
    cmd.rem          = room ? CNT_W'(BITS_PER_PIXEL - 1) : CNT_W'(nlatch - LATCH_W'(1));
    if (take) begin
      if (pixel.mode == MODE_START) begin
        pixels_sent_next = '0;
        latched_next     = 1'b0;
      end else if (!latched) begin
        push = 1'b1;
        if (room) begin
          pixels_sent_next = pixels_sent + LENGTH_W'(1);
        end else begin
          latched_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_sent <= '0;
      latched     <= 1'b1;
    end else begin
      pixels_sent <= pixels_sent_next;
      latched     <= latched_next;
    end
  end

endmodule

// File: rtl/rlse_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_queue
// short run queue between the front and the slot generator
// ---------------------------------------------------------------------------
module rlse_queue import rlse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    wr,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_CNT_W-1:0] count;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign head          = mem[rptr];
  assign stat.full     = count == Q_CNT_W'(Q_DEPTH);
  assign stat.nonempty = count != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/rlse_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_back
// expands queued runs into slots, one per cycle while the output is taken, msb first
// ---------------------------------------------------------------------------
module rlse_back import rlse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  q_stat_t  q_st,
  input  cmd_t     head,
  output logic     pop,
  rlse_out_if.source slot
);

  logic              act;
  cmd_t              cur;
  cmd_t              src;
  logic              have_src;
  logic              adv;
  logic              emit;
  logic              ovalid;
  logic [DUTY_W-1:0] oduty;
  logic              oreset;
  logic              olast;
  logic [DUTY_W-1:0] duty;

  // the first slot of a run comes straight from the queue head
  assign src      = act ? cur : head;
  assign have_src = act || q_st.nonempty;
  assign adv      = !ovalid || slot.ready;
  assign emit     = adv && have_src;
  assign pop      = emit && !act;

  always_comb begin
    if (src.is_latch) begin
      duty = '0;
    end else if (src.grb[BITS_PER_PIXEL-1]) begin
      duty = cfg.one_duty;
    end else begin
      duty = cfg.zero_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (adv) begin
        ovalid <= have_src;
      end
      if (emit) begin
        act <= src.rem != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cur.is_latch <= src.is_latch;
      cur.grb      <= src.grb << 1;
      cur.rem      <= src.rem - CNT_W'(1);
      oduty        <= duty;
      oreset       <= src.is_latch;
      olast        <= src.rem == '0;
    end
  end

  assign slot.valid       = ovalid;
  assign slot.slot_duty   = oduty;
  assign slot.reset_slot  = oreset;
  assign slot.last_of_run = olast;

endmodule

// File: rtl/rgb_led_strip_bit_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_led_strip_bit_encoder
// one-wire led strip frame encoder, grb words to pulse duty slots
// ---------------------------------------------------------------------------
// A start word opens a frame; each pixel word then yields 24 duty slots, msb
// of the grb word first, and the pixel after the strip is full yields the
// reset run of latch_slots zero-duty slots (1 to 48) that closes the frame.
// The slot generator puts out one slot per cycle unless the output stalls, so
// a pixel occupies it for its 24 slots and a reset run for latch_slots slots;
// start words and pixels outside a frame are absorbed by the front end and
// never queued. A two-run queue sits between front end and generator, so the
// next pixel word is taken while the current run is still being sent, and a
// run already queued follows the last with no gap. The output register holds
// a slot until it is taken. There is no clearing pass after reset.
module rgb_led_strip_bit_encoder import rlse_pkg::*; #(
  parameter int MAX_LEDS        = MAX_LEDS_DEF,
  parameter int MAX_LATCH_SLOTS = MAX_LATCH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  rlse_in_if.sink           pixel,
  rlse_out_if.source        slot,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t        cfg;
  q_stat_t     q_st;
  front_stat_t front_st;
  logic        push;
  logic        pop;
  cmd_t        wr_cmd;
  cmd_t        head;

  rlse_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlse_front #(
    .MAX_LEDS        (MAX_LEDS),
    .MAX_LATCH_SLOTS (MAX_LATCH_SLOTS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .cfg   (cfg),
    .q_st  (q_st),
    .push  (push),
    .cmd   (wr_cmd),
    .stat  (front_st)
  );

  rlse_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wr   (wr_cmd),
    .pop  (pop),
    .head (head),
    .stat (q_st)
  );

  rlse_back u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .q_st (q_st),
    .head (head),
    .pop  (pop),
    .slot (slot)
  );

`include "rgb_led_strip_bit_encoder_assert.svh"

  // a run never breaks up once its first slot is taken
  `RLSE_CHECK(a_run_continuous, slot.valid && slot.ready && !slot.last_of_run |=> slot.valid, "slot run broke off before its last slot")

  // reset slots always carry zero duty
  `RLSE_CHECK(a_reset_zero_duty, slot.valid && slot.reset_slot |-> slot.slot_duty == '0, "reset slot with nonzero duty")

  // pixel count stays within the largest strip, the count is unknown until reset
  `RLSE_CHECK_ALWAYS(a_count_bound, rst || 32'(front_st.pixels_sent) <= 32'(MAX_LEDS),
    "pixel count beyond strip limit")

endmodule
